FILE: src/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared constants and types for the multi-queue shared buffer unit.
// ----------------------------------------------------------------------------
package mqsb_pkg;

	localparam int DEF_NUM_ENTRIES = 16;
	localparam int DEF_NUM_QUEUES  = 4;

	localparam int DATA_W  = 32;
	localparam int QID_W   = 2;
	localparam int STAT_W  = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	// write strobes into the entry store
	typedef struct packed {
		logic link_we;
		logic data_we;
	} entry_wr_t;

endpackage

FILE: src/mqsb_queue_table.sv
// ----------------------------------------------------------------------------
// mqsb_queue_table
// Per-queue head and tail pointer memory, one read and one write port.
// ----------------------------------------------------------------------------
module mqsb_queue_table #(
	parameter int NUM_ENTRIES = mqsb_pkg::DEF_NUM_ENTRIES,
	parameter int NUM_QUEUES  = mqsb_pkg::DEF_NUM_QUEUES,
	localparam int EW = $clog2(NUM_ENTRIES),
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [QW-1:0] rd_addr,
	output logic [EW-1:0] rd_head,
	output logic [EW-1:0] rd_tail,
	input  logic          wr_en,
	input  logic [QW-1:0] wr_addr,
	input  logic [EW-1:0] wr_head,
	input  logic [EW-1:0] wr_tail
);

	logic [2*EW-1:0] mem [NUM_QUEUES];
	logic [2*EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_head, wr_tail};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_head = rd_q[2*EW-1:EW];
	assign rd_tail = rd_q[EW-1:0];

endmodule

FILE: src/mqsb_entry_store.sv
// ----------------------------------------------------------------------------
// mqsb_entry_store
// Shared entry storage: next-entry link and data word per entry.
// ----------------------------------------------------------------------------
module mqsb_entry_store #(
	parameter int NUM_ENTRIES = mqsb_pkg::DEF_NUM_ENTRIES,
	localparam int EW = $clog2(NUM_ENTRIES)
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [EW-1:0]                  rd_addr,
	output logic [EW-1:0]                  rd_link,
	output logic [mqsb_pkg::DATA_W-1:0]    rd_data,
	input  mqsb_pkg::entry_wr_t            wr,
	input  logic [EW-1:0]                  link_waddr,
	input  logic [EW-1:0]                  link_wdata,
	input  logic [EW-1:0]                  data_waddr,
	input  logic [mqsb_pkg::DATA_W-1:0]    data_wdata
);

	logic [EW-1:0]               link_mem [NUM_ENTRIES];
	logic [mqsb_pkg::DATA_W-1:0] data_mem [NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (wr.data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_link <= link_mem[rd_addr];
			rd_data <= data_mem[rd_addr];
		end
	end

endmodule

FILE: src/multi_queue_shared_buffer_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit
// Several FIFO queues linked through one shared entry store with a free list.
// ----------------------------------------------------------------------------
// Timing: the result is registered in ST_LOOK for an enqueue, a refused
//   enqueue or an underflow, and in ST_FETCH for a successful dequeue.
// Throughput: one request in flight; the next is taken only back in ST_IDLE,
//   after the queue table read and, for a dequeue, the dependent entry store read.
// Reset: clears control, queue valid bits and the free list; the initial
//   free chain comes from a watermark, so no clearing pass is needed.
module multi_queue_shared_buffer_unit #(
	parameter int NUM_ENTRIES = mqsb_pkg::DEF_NUM_ENTRIES,
	parameter int NUM_QUEUES  = mqsb_pkg::DEF_NUM_QUEUES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic signed [31:0]     s_axis_tdata,   // [31:0] value_in
	input  logic [2:0]             s_axis_tuser,   // [0] command, [2:1] queue_id
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic signed [31:0]     m_axis_tdata,   // [31:0] value_out
	output logic [1:0]             m_axis_tuser    // [1:0] status
);

	localparam int EW = $clog2(NUM_ENTRIES);
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int DW = mqsb_pkg::DATA_W;
	localparam int IW = mqsb_pkg::QID_W;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_FETCH} state_t;

	state_t                    state_q;
	logic                      cmd_q;
	logic [QW-1:0]             qsel_q;
	logic [DW-1:0]             val_q;
	logic                      ne_q;
	logic [NUM_QUEUES-1:0]     nonempty_q;
	logic [EW-1:0]             free_head_q;
	logic [CW-1:0]             free_cnt_q;
	logic [CW-1:0]             wm_q;
	logic                      m_valid_q;
	logic [DW-1:0]             m_data_q;
	logic [1:0]                m_user_q;

	logic                      accept;
	logic                      out_free;
	logic                      res_done;
	logic [QW-1:0]             qsel;
	logic                      qt_rd_en;
	logic [EW-1:0]             qt_head;
	logic [EW-1:0]             qt_tail;
	logic                      qt_wr_en;
	logic [EW-1:0]             qt_wr_head;
	logic [EW-1:0]             qt_wr_tail;
	logic                      es_rd_en;
	logic [EW-1:0]             es_rd_addr;
	logic [EW-1:0]             es_link;
	logic [DW-1:0]             es_data;
	mqsb_pkg::entry_wr_t       es_wr;
	logic [EW-1:0]             link_waddr;
	logic [EW-1:0]             link_wdata;
	logic                      fresh;
	logic [EW-1:0]             seq_next;
	logic [EW-1:0]             free_next;
	logic                      deq_last;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// result for the request in flight is produced at this edge
	assign res_done = out_free && (state_q == ST_FETCH || (state_q == ST_LOOK
		&& !(cmd_q == mqsb_pkg::CMD_DEQ && ne_q)));

	// queue number folded into range when fewer than four queues exist
	always_comb begin
		logic [IW-1:0] x;
		x = s_axis_tuser[2:1];
		for (int i = 0; i < 3; i++) begin
			if (NUM_QUEUES < 4 && x >= IW'(NUM_QUEUES)) begin
				x = x - IW'(NUM_QUEUES);
			end
		end
		qsel = QW'(x);
	end

	// an entry at the watermark was never linked: its link is the reset chain
	assign fresh     = (CW'(free_head_q) == wm_q);
	assign seq_next  = (free_head_q == EW'(NUM_ENTRIES - 1)) ? '0 : free_head_q + 1'b1;
	assign free_next = fresh ? seq_next : es_link;
	assign deq_last  = (qt_head == qt_tail);

	assign qt_rd_en = accept;

	always_comb begin
		es_rd_en   = 1'b0;
		es_rd_addr = free_head_q;
		if (accept) begin
			es_rd_en = 1'b1;
		end else if (state_q == ST_LOOK && cmd_q == mqsb_pkg::CMD_DEQ && ne_q) begin
			es_rd_en   = 1'b1;
			es_rd_addr = qt_head;
		end
	end

	always_comb begin
		qt_wr_en   = 1'b0;
		qt_wr_head = qt_head;
		qt_wr_tail = qt_tail;
		es_wr      = '0;
		link_waddr = qt_tail;
		link_wdata = free_head_q;
		if (state_q == ST_LOOK && cmd_q == mqsb_pkg::CMD_ENQ && out_free
			&& free_cnt_q != '0) begin
			qt_wr_en       = 1'b1;
			qt_wr_head     = ne_q ? qt_head : free_head_q;
			qt_wr_tail     = free_head_q;
			es_wr.data_we  = 1'b1;
			es_wr.link_we  = ne_q;
			link_waddr     = qt_tail;
			link_wdata     = free_head_q;
		end else if (state_q == ST_FETCH && out_free) begin
			qt_wr_en       = !deq_last;
			qt_wr_head     = es_link;
			qt_wr_tail     = qt_tail;
			es_wr.link_we  = 1'b1;
			link_waddr     = qt_head;
			link_wdata     = free_head_q;
		end
	end

	mqsb_queue_table #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.NUM_QUEUES (NUM_QUEUES)
	) u_qtab (
		.clk    (clk),
		.rd_en  (qt_rd_en),
		.rd_addr(qsel),
		.rd_head(qt_head),
		.rd_tail(qt_tail),
		.wr_en  (qt_wr_en),
		.wr_addr(qsel_q),
		.wr_head(qt_wr_head),
		.wr_tail(qt_wr_tail)
	);

	mqsb_entry_store #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_store (
		.clk       (clk),
		.rd_en     (es_rd_en),
		.rd_addr   (es_rd_addr),
		.rd_link   (es_link),
		.rd_data   (es_data),
		.wr        (es_wr),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.data_waddr(free_head_q),
		.data_wdata(val_q)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_axis_tuser[0];
			qsel_q <= qsel;
			val_q  <= s_axis_tdata;
			ne_q   <= nonempty_q[qsel];
		end
		if (res_done) begin
			if (state_q == ST_FETCH) begin
				m_data_q <= es_data;
				m_user_q <= mqsb_pkg::STATUS_OK;
			end else if (cmd_q == mqsb_pkg::CMD_ENQ && free_cnt_q == '0) begin
				m_data_q <= '0;
				m_user_q <= mqsb_pkg::STATUS_FULL;
			end else if (cmd_q == mqsb_pkg::CMD_ENQ) begin
				m_data_q <= '0;
				m_user_q <= mqsb_pkg::STATUS_OK;
			end else begin
				m_data_q <= '1;
				m_user_q <= mqsb_pkg::STATUS_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nonempty_q  <= '0;
			free_head_q <= '0;
			free_cnt_q  <= CW'(NUM_ENTRIES);
			wm_q        <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (res_done) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (cmd_q == mqsb_pkg::CMD_DEQ && ne_q) begin
						state_q <= ST_FETCH;
					end else if (out_free) begin
						state_q   <= ST_IDLE;
						if (cmd_q == mqsb_pkg::CMD_ENQ && free_cnt_q != '0) begin
							nonempty_q[qsel_q] <= 1'b1;
							free_head_q        <= free_next;
							free_cnt_q         <= free_cnt_q - 1'b1;
							if (fresh) begin
								wm_q <= wm_q + 1'b1;
							end
						end
					end
				end
				ST_FETCH: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						free_head_q <= qt_head;
						free_cnt_q  <= free_cnt_q + 1'b1;
						if (deq_last) begin
							nonempty_q[qsel_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_free_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CW'(NUM_ENTRIES))
		else $error("free count above store size");

	a_wm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wm_q <= CW'(NUM_ENTRIES))
		else $error("watermark above store size");

	a_underflow_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == mqsb_pkg::STATUS_EMPTY |-> m_axis_tdata == '1)
		else $error("underflow result not all ones");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second request taken while one is in flight");

	a_fetch_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> free_cnt_q != CW'(NUM_ENTRIES))
		else $error("dequeue fetch with every entry free");

endmodule

FILE: tb/mqsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_checker
// Watches both stream channels of the multi-queue shared buffer unit, keeps
// its own linked-list image of the queues and the free list, and compares
// every returned result against the oldest predicted one.
// ----------------------------------------------------------------------------
module mqsb_checker #(
	parameter int NUM_ENTRIES = mqsb_pkg::DEF_NUM_ENTRIES,
	parameter int NUM_QUEUES  = mqsb_pkg::DEF_NUM_QUEUES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [mqsb_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] value_in
	input  logic [mqsb_pkg::QID_W:0]      s_axis_tuser,   // [0] command, [2:1] queue_id
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [mqsb_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] value_out
	input  logic [mqsb_pkg::STAT_W-1:0]   m_axis_tuser,   // [1:0] status
	output int                            fail_count,
	output int                            pending
);

	localparam int PTR_W = $clog2(NUM_ENTRIES);
	localparam int DW    = mqsb_pkg::DATA_W;
	localparam int SW    = mqsb_pkg::STAT_W;
	localparam int IW    = mqsb_pkg::QID_W;

	typedef struct {
		logic [DW-1:0] value;
		logic [SW-1:0] status;
	} queue_reply_t;

	logic [PTR_W-1:0]  q_head [NUM_QUEUES];
	logic [PTR_W-1:0]  q_tail [NUM_QUEUES];
	logic              q_live [NUM_QUEUES];
	logic [PTR_W-1:0]  link_next [NUM_ENTRIES];
	logic [DW-1:0]     stored_word [NUM_ENTRIES];
	logic [PTR_W-1:0]  free_head;
	int                free_left;

	queue_reply_t expected_replies [$];

	function automatic queue_reply_t apply_queue_op(input logic cmd,
			input logic [IW-1:0] qid_raw, input logic [DW-1:0] word);
		queue_reply_t r;
		int q;
		logic [PTR_W-1:0] e;
		q = int'(qid_raw) % NUM_QUEUES;
		r.value = '0;
		r.status = mqsb_pkg::STATUS_OK;
		if (cmd == mqsb_pkg::CMD_ENQ) begin
			if (free_left == 0) begin
				r.status = mqsb_pkg::STATUS_FULL;
			end else begin
				e = free_head;
				free_head = link_next[e];
				free_left--;
				if (q_live[q])
					link_next[q_tail[q]] = e;
				else
					q_head[q] = e;
				q_tail[q] = e;
				q_live[q] = 1'b1;
				stored_word[e] = word;
			end
		end else if (!q_live[q]) begin
			r.status = mqsb_pkg::STATUS_EMPTY;
			r.value = '1;
		end else begin
			e = q_head[q];
			// removing the only entry just drops the valid bit
			if (e == q_tail[q])
				q_live[q] = 1'b0;
			else
				q_head[q] = link_next[e];
			link_next[e] = free_head;
			free_head = e;
			if (free_left < NUM_ENTRIES)
				free_left++;
			r.value = stored_word[e];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				q_head[i] = '0;
				q_tail[i] = '0;
				q_live[i] = 1'b0;
			end
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				link_next[i] = PTR_W'((i + 1) % NUM_ENTRIES);
				stored_word[i] = '0;
			end
			free_head = '0;
			free_left = NUM_ENTRIES;
			expected_replies.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					$error("result with no request outstanding: value_out %0d status %0d",
						$signed(m_axis_tdata), m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("value_out mismatch: expected %0d, got %0d",
							$signed(want.value), $signed(m_axis_tdata));
						fail_count++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, m_axis_tuser);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(apply_queue_op(s_axis_tuser[0],
					s_axis_tuser[IW:1], s_axis_tdata));
			pending = expected_replies.size();
		end
	end

endmodule

FILE: tb/multi_queue_shared_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit_test
// Drives enqueue and dequeue requests into the shared buffer unit: a directed
// fill/overflow/underflow sequence, then biased random bursts under three
// back-pressure profiles. Checking is done by mqsb_checker.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_unit_test;

	localparam int STALL_LIMIT = 4000;
	localparam int DW = mqsb_pkg::DATA_W;
	localparam int IW = mqsb_pkg::QID_W;
	localparam int SW = mqsb_pkg::STAT_W;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [DW-1:0]       s_axis_tdata;   // [31:0] value_in
	logic [IW:0]         s_axis_tuser;   // [0] command, [2:1] queue_id
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [DW-1:0]       m_axis_tdata;   // [31:0] value_out
	logic [SW-1:0]       m_axis_tuser;   // [1:0] status

	int fail_count;
	int pending;
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_cycles;

	always #2 clk = ~clk;

	multi_queue_shared_buffer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	mqsb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high so back-to-back requests need no extra assignment
	task automatic push_request(input logic cmd, input logic [IW-1:0] qid,
			input logic [DW-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = {qid, cmd};
		s_axis_tdata = word;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_replies();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// bursts lean toward enqueue, toward dequeue or to neither, so the store swings between
	// full and empty; some bursts hammer a single queue
	task automatic run_random_items(input int n_items);
		int sent;
		int burst_len;
		int enq_bias;
		int focus_q;
		logic focused;
		logic cmd;
		logic [IW-1:0] qid;
		sent = 0;
		while (sent < n_items) begin
			burst_len = $urandom_range(40, 8);
			case ($urandom_range(2))
				0: enq_bias = 15;
				1: enq_bias = 50;
				default: enq_bias = 85;
			endcase
			focused = ($urandom_range(9) < 3);
			focus_q = $urandom_range(3);
			for (int k = 0; k < burst_len && sent < n_items; k++) begin
				cmd = ($urandom_range(99) < enq_bias) ? mqsb_pkg::CMD_ENQ : mqsb_pkg::CMD_DEQ;
				qid = focused ? IW'(focus_q) : IW'($urandom_range(3));
				push_request(cmd, qid, pick_word());
				sent++;
			end
			if ($urandom_range(9) == 0)
				drain_replies();
		end
		drain_replies();
	endtask

	initial begin
		logic [DW-1:0] fill_words [16];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		tx_idle_pct = 14;
		rx_idle_pct = 88;
		fill_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE,
			32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			32'h3333_CCCC, 32'hCCCC_3333, 32'h00FF_FF00, 32'hFF00_00FF};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// underflow on a queue never written
		push_request(mqsb_pkg::CMD_DEQ, 2'd3, 32'hAAAA_5555);
		// fill the whole store, round robin over the queues
		for (int i = 0; i < 16; i++)
			push_request(mqsb_pkg::CMD_ENQ, IW'(i % 4), fill_words[i]);
		// store full, request refused
		push_request(mqsb_pkg::CMD_ENQ, 2'd2, 32'h5555_AAAA);
		// empty queue 0 and underflow it once, then dequeue from queue 3
		for (int i = 0; i < 5; i++)
			push_request(mqsb_pkg::CMD_DEQ, 2'd0, 32'hFFFF_FFFF);
		push_request(mqsb_pkg::CMD_DEQ, 2'd3, 32'h0000_0000);
		drain_replies();

		run_random_items(575);
		tx_idle_pct = 88;
		rx_idle_pct = 14;
		run_random_items(575);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random_items(575);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/mqsb_pkg.sv
src/mqsb_queue_table.sv
src/mqsb_entry_store.sv
src/multi_queue_shared_buffer_unit.sv
tb/mqsb_checker.sv
tb/multi_queue_shared_buffer_unit_test.sv
